// ----- design/rmfa_pkg.sv -----
// shared constants, types and functions for the rotation matrix unit
package rmfa_pkg;

    localparam int ANGLE_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int IN_ANGLE_W        = 16;
    localparam int CORDIC_STEPS      = 28;
    localparam int WORK_FRAC         = 30;
    localparam int WORK_W            = 34;
    localparam int PHASE_W           = 32;
    localparam int Z_W               = 32;

    typedef logic signed [WORK_W-1:0] t_work;

    typedef enum logic {
        OP_ATTITUDE = 1'b0,
        OP_FRAME    = 1'b1
    } t_op;

    typedef struct packed {
        logic signed [WORK_W-1:0] x;
        logic signed [WORK_W-1:0] y;
        logic signed [Z_W-1:0]    z;
        logic [1:0]               quad;
    } t_cordic;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic signed [Z_W-1:0] atan_turn(input logic [4:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:  v = 32'sd536870912;
            5'd1:  v = 32'sd316933406;
            5'd2:  v = 32'sd167458907;
            5'd3:  v = 32'sd85004756;
            5'd4:  v = 32'sd42667331;
            5'd5:  v = 32'sd21354465;
            5'd6:  v = 32'sd10679838;
            5'd7:  v = 32'sd5340245;
            5'd8:  v = 32'sd2670163;
            5'd9:  v = 32'sd1335087;
            5'd10: v = 32'sd667544;
            5'd11: v = 32'sd333772;
            5'd12: v = 32'sd166886;
            5'd13: v = 32'sd83443;
            5'd14: v = 32'sd41722;
            5'd15: v = 32'sd20861;
            5'd16: v = 32'sd10430;
            5'd17: v = 32'sd5215;
            5'd18: v = 32'sd2608;
            5'd19: v = 32'sd1304;
            5'd20: v = 32'sd652;
            5'd21: v = 32'sd326;
            5'd22: v = 32'sd163;
            5'd23: v = 32'sd81;
            5'd24: v = 32'sd41;
            5'd25: v = 32'sd20;
            5'd26: v = 32'sd10;
            5'd27: v = 32'sd5;
            default: v = '0;
        endcase
        return v;
    endfunction

    // q30 product, round half up
    function automatic t_work qmul(input t_work a, input t_work b);
        logic signed [2*WORK_W-1:0] p;
        p = a * b + (68'sd1 <<< (WORK_FRAC - 1));
        return t_work'(p >>> WORK_FRAC);
    endfunction

endpackage

// ----- design/rmfa_cordic_cell.sv -----
// one cordic micro-rotation stage for three angle lanes
module rmfa_cordic_cell
    import rmfa_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_vld,
    input  logic    i_op,
    input  t_cordic i_lane [3],
    output logic    o_vld,
    output logic    o_op,
    output t_cordic o_lane [3]
);

    localparam logic signed [Z_W-1:0] ATAN = atan_turn(5'(STEP));

    logic    r_vld;
    logic    r_op;
    t_cordic r_lane [3];
    t_cordic n_lane [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_lane[k].quad = i_lane[k].quad;
            if (!i_lane[k].z[Z_W-1]) begin
                n_lane[k].x = i_lane[k].x - (i_lane[k].y >>> STEP);
                n_lane[k].y = i_lane[k].y + (i_lane[k].x >>> STEP);
                n_lane[k].z = i_lane[k].z - ATAN;
            end else begin
                n_lane[k].x = i_lane[k].x + (i_lane[k].y >>> STEP);
                n_lane[k].y = i_lane[k].y - (i_lane[k].x >>> STEP);
                n_lane[k].z = i_lane[k].z + ATAN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_op   <= i_op;
        r_lane <= n_lane;
    end

    assign o_vld  = r_vld;
    assign o_op   = r_op;
    assign o_lane = r_lane;

endmodule

// ----- design/rmfa_matrix.sv -----
// product stages that form the nine matrix elements from sines and cosines
module rmfa_matrix
    import rmfa_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_vld,
    input  logic    i_op,
    input  t_cordic i_lane [3],
    output logic    o_vld,
    output logic signed [FRACTION_BITS+1:0] o_elem [9]
);

    localparam int SHIFT = WORK_FRAC - FRACTION_BITS;
    localparam int OW    = FRACTION_BITS + 2;

    function automatic logic signed [OW-1:0] to_out(input t_work v);
        t_work r;
        t_work lim;
        lim = t_work'(1) <<< FRACTION_BITS;
        r   = (v + (t_work'(1) <<< (SHIFT - 1))) >>> SHIFT;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r[OW-1:0];
    endfunction

    // stage 1: quadrant fold
    t_work n_s [3];
    t_work n_c [3];
    t_work r_s [3];
    t_work r_c [3];
    logic  r_vld1, r_op1;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            case (i_lane[k].quad)
                2'd0: begin n_c[k] = i_lane[k].x;  n_s[k] = i_lane[k].y;  end
                2'd1: begin n_c[k] = -i_lane[k].y; n_s[k] = i_lane[k].x;  end
                2'd2: begin n_c[k] = -i_lane[k].x; n_s[k] = -i_lane[k].y; end
                default: begin n_c[k] = i_lane[k].y; n_s[k] = -i_lane[k].x; end
            endcase
        end
    end

    // stage 2: first products
    t_work r_sp_sr, r_sp_cr, r_c3c2, r_s3c2, r_c2s1, r_c2c1;
    t_work r_s1c2, r_s1s2, r_c1c2, r_c1s2;
    t_work r2_s [3];
    t_work r2_c [3];
    logic  r_vld2, r_op2;

    // stage 3: second products
    t_work r_a, r_b, r_ca, r_d, r_e, r_f, r_g, r_h;
    t_work r3_s [3];
    t_work r3_c [3];
    t_work r3_c3c2, r3_s3c2, r3_c2s1, r3_c2c1;
    t_work r3_s1c2, r3_s1s2, r3_c1c2, r3_c1s2;
    logic  r_vld3, r_op3;

    // stage 4: sums and output conversion
    t_work n_m [9];
    logic signed [OW-1:0] r_elem [9];
    logic  r_vld4;

    always_comb begin
        if (r_op3 == OP_ATTITUDE) begin
            n_m[0] = r3_c3c2;
            n_m[1] = r_a - r_b;
            n_m[2] = r_ca + r_d;
            n_m[3] = r3_s3c2;
            n_m[4] = r_e + r_f;
            n_m[5] = r_g - r_h;
            n_m[6] = -r3_s[1];
            n_m[7] = r3_c2s1;
            n_m[8] = r3_c2c1;
        end else begin
            n_m[0] = -r3_s1c2;
            n_m[1] = -r3_s[1];
            n_m[2] = -r3_c1c2;
            n_m[3] = -r3_s1s2;
            n_m[4] = r3_c[1];
            n_m[5] = -r3_c1s2;
            n_m[6] = r3_c[0];
            n_m[7] = '0;
            n_m[8] = -r3_s[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
            r_vld4 <= r_vld3;
        end
        r_op1 <= i_op;
        r_s   <= n_s;
        r_c   <= n_c;

        r_op2   <= r_op1;
        r2_s    <= r_s;
        r2_c    <= r_c;
        r_sp_sr <= qmul(r_s[1], r_s[0]);
        r_sp_cr <= qmul(r_s[1], r_c[0]);
        r_c3c2  <= qmul(r_c[2], r_c[1]);
        r_s3c2  <= qmul(r_s[2], r_c[1]);
        r_c2s1  <= qmul(r_c[1], r_s[0]);
        r_c2c1  <= qmul(r_c[1], r_c[0]);
        r_s1c2  <= qmul(r_s[0], r_c[1]);
        r_s1s2  <= qmul(r_s[0], r_s[1]);
        r_c1c2  <= qmul(r_c[0], r_c[1]);
        r_c1s2  <= qmul(r_c[0], r_s[1]);

        r_op3   <= r_op2;
        r3_s    <= r2_s;
        r3_c    <= r2_c;
        r3_c3c2 <= r_c3c2;
        r3_s3c2 <= r_s3c2;
        r3_c2s1 <= r_c2s1;
        r3_c2c1 <= r_c2c1;
        r3_s1c2 <= r_s1c2;
        r3_s1s2 <= r_s1s2;
        r3_c1c2 <= r_c1c2;
        r3_c1s2 <= r_c1s2;
        r_a  <= qmul(r2_c[2], r_sp_sr);
        r_b  <= qmul(r2_s[2], r2_c[0]);
        r_ca <= qmul(r2_c[2], r_sp_cr);
        r_d  <= qmul(r2_s[2], r2_s[0]);
        r_e  <= qmul(r2_s[2], r_sp_sr);
        r_f  <= qmul(r2_c[2], r2_c[0]);
        r_g  <= qmul(r2_s[2], r_sp_cr);
        r_h  <= qmul(r2_c[2], r2_s[0]);

        for (int k = 0; k < 9; k++) begin
            r_elem[k] <= to_out(n_m[k]);
        end
    end

    assign o_vld  = r_vld4;
    assign o_elem = r_elem;

endmodule

// ----- design/rotation_matrix_from_angles_unit.sv -----
// top level: rotation matrix from euler or lat/lon angles
//
// channel  | signals                                   | direction
// request  | i_start, o_busy, i_operation, angle ports | in
// result   | o_valid, o_elem_r0_c0 .. o_elem_r2_c2     | out
//
// one request per cycle; o_busy is always low
// the path is an input register, 28 cordic cells and 4 product stages
// synchronous active-low reset clears all valid bits
// the result strobe lasts one cycle and cannot be held off
module rotation_matrix_from_angles_unit
    import rmfa_pkg::*;
#(
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    output logic o_busy,
    input  logic i_operation,
    input  logic signed [IN_ANGLE_W-1:0] i_roll_or_latitude,
    input  logic signed [IN_ANGLE_W-1:0] i_pitch_or_longitude,
    input  logic signed [IN_ANGLE_W-1:0] i_yaw_angle,
    output logic o_valid,
    output logic signed [FRACTION_BITS+1:0] o_elem_r0_c0,
    output logic signed [FRACTION_BITS+1:0] o_elem_r0_c1,
    output logic signed [FRACTION_BITS+1:0] o_elem_r0_c2,
    output logic signed [FRACTION_BITS+1:0] o_elem_r1_c0,
    output logic signed [FRACTION_BITS+1:0] o_elem_r1_c1,
    output logic signed [FRACTION_BITS+1:0] o_elem_r1_c2,
    output logic signed [FRACTION_BITS+1:0] o_elem_r2_c0,
    output logic signed [FRACTION_BITS+1:0] o_elem_r2_c1,
    output logic signed [FRACTION_BITS+1:0] o_elem_r2_c2
);

    localparam logic signed [WORK_W-1:0] X_INIT = 34'sd652032874;

    function automatic t_cordic seed(input logic signed [IN_ANGLE_W-1:0] a);
        logic [PHASE_W-1:0] ph;
        t_cordic c;
        ph     = PHASE_W'(PHASE_W'(signed'(a)) << (PHASE_W - ANGLE_BITS));
        c.x    = X_INIT;
        c.y    = '0;
        c.quad = ph[PHASE_W-1:PHASE_W-2];
        c.z    = Z_W'({2'b00, ph[PHASE_W-3:0]});
        return c;
    endfunction

    logic    r_vld;
    logic    r_op;
    t_cordic r_seed [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_start;
        end
        r_op      <= i_operation;
        r_seed[0] <= seed(i_roll_or_latitude);
        r_seed[1] <= seed(i_pitch_or_longitude);
        r_seed[2] <= seed(i_yaw_angle);
    end

    logic    w_vld  [CORDIC_STEPS+1];
    logic    w_op   [CORDIC_STEPS+1];
    t_cordic w_lane [CORDIC_STEPS+1][3];

    assign w_vld[0]  = r_vld;
    assign w_op[0]   = r_op;
    assign w_lane[0] = r_seed;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        rmfa_cordic_cell #(.STEP(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (w_vld[g]),
            .i_op   (w_op[g]),
            .i_lane (w_lane[g]),
            .o_vld  (w_vld[g+1]),
            .o_op   (w_op[g+1]),
            .o_lane (w_lane[g+1])
        );
    end

    logic signed [FRACTION_BITS+1:0] w_elem [9];

    rmfa_matrix #(.FRACTION_BITS(FRACTION_BITS)) u_matrix (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (w_vld[CORDIC_STEPS]),
        .i_op   (w_op[CORDIC_STEPS]),
        .i_lane (w_lane[CORDIC_STEPS]),
        .o_vld  (o_valid),
        .o_elem (w_elem)
    );

    assign o_busy       = 1'b0;
    assign o_elem_r0_c0 = w_elem[0];
    assign o_elem_r0_c1 = w_elem[1];
    assign o_elem_r0_c2 = w_elem[2];
    assign o_elem_r1_c0 = w_elem[3];
    assign o_elem_r1_c1 = w_elem[4];
    assign o_elem_r1_c2 = w_elem[5];
    assign o_elem_r2_c0 = w_elem[6];
    assign o_elem_r2_c1 = w_elem[7];
    assign o_elem_r2_c2 = w_elem[8];

endmodule

// ----- design/rmfa_checker.sv -----
// port-level checks for the rotation matrix unit, with bind
module rmfa_checker
    import rmfa_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_valid,
    input logic signed [FRACTION_BITS+1:0] o_elem_r0_c0,
    input logic signed [FRACTION_BITS+1:0] o_elem_r2_c2
);

    localparam int LAT = CORDIC_STEPS + 5;

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy) else $error("busy raised");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LAT o_valid) else $error("missing result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, LAT)) else $error("spurious result");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_elem_r0_c0 <= (1 <<< FRACTION_BITS)
                  && o_elem_r0_c0 >= -(1 <<< FRACTION_BITS)
                  && o_elem_r2_c2 <= (1 <<< FRACTION_BITS)
                  && o_elem_r2_c2 >= -(1 <<< FRACTION_BITS)))
        else $error("element out of range");

endmodule

bind rotation_matrix_from_angles_unit rmfa_checker #(.FRACTION_BITS(FRACTION_BITS)) u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .o_valid     (o_valid),
    .o_elem_r0_c0(o_elem_r0_c0),
    .o_elem_r2_c2(o_elem_r2_c2)
);
